// ===== hw/rtl/bitmap_search_engine_assert.svh =====
// assertion helpers for the rtl files
`ifndef BITMAP_SEARCH_ENGINE_ASSERT_SVH
`define BITMAP_SEARCH_ENGINE_ASSERT_SVH

// checked on every rising edge, skipped while reset is high
`define BSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define BSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bse_pkg.sv =====
package bse_pkg;

   localparam int SIZE_BITS = 1024;
   localparam int WORD_W    = 64;
   localparam int OFF_W     = 6;
   localparam int WORDS     = (SIZE_BITS + WORD_W - 1) / WORD_W;
   localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;

   localparam int KIND_W = 4;
   localparam int POS_W  = 12;
   localparam int END_W  = 11;
   localparam int CNT_W  = 11;
   localparam int LEN_W  = 7;

   localparam int PAD_BITS = SIZE_BITS % WORD_W;
   // valid bits of the last stored word
   localparam logic [WORD_W-1:0] LAST_MASK =
      (PAD_BITS == 0) ? {WORD_W{1'b1}} : (({{(WORD_W-1){1'b0}}, 1'b1} << PAD_BITS) - 1'b1);

   typedef enum logic [KIND_W-1:0] {
      K_WRITE      = 4'd0,
      K_FLIP       = 4'd1,
      K_READ       = 4'd2,
      K_NEXT_SET   = 4'd3,
      K_NEXT_UNSET = 4'd4,
      K_PREV_SET   = 4'd5,
      K_PREV_UNSET = 4'd6,
      K_COUNT      = 4'd7,
      K_CLEAR_ALL  = 4'd8,
      K_SET_ALL    = 4'd9,
      K_SLICE      = 4'd10
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RMW,
      ST_WALK,
      ST_SCAN,
      ST_COUNT,
      ST_FILL,
      ST_SLICE0,
      ST_SLICE1,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [WIDX_W-1:0] rd_addr;
      logic              wr_en;
      logic [WIDX_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              clr_all;
   } mem_req_type;

   typedef struct packed {
      logic                    bit_out;
      logic signed [POS_W-1:0] found_index;
      logic [CNT_W-1:0]        ones_count;
      logic [WORD_W-1:0]       slice_bits;
   } res_type;

endpackage

// ===== hw/rtl/bse_if.sv =====
interface bse_req_if;
   logic                             valid;
   logic                             ready;
   logic [bse_pkg::KIND_W-1:0]       kind;
   logic signed [bse_pkg::POS_W-1:0] position;
   logic [bse_pkg::END_W-1:0]        end_position;
   logic                             write_value;

   modport source (output valid, kind, position, end_position, write_value, input ready);
   modport sink (input valid, kind, position, end_position, write_value, output ready);
endinterface

interface bse_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             bit_out;
   logic signed [bse_pkg::POS_W-1:0] found_index;
   logic [bse_pkg::CNT_W-1:0]        ones_count;
   logic [bse_pkg::WORD_W-1:0]       slice_bits;

   modport source (output valid, bit_out, found_index, ones_count, slice_bits, input ready);
   modport sink (input valid, bit_out, found_index, ones_count, slice_bits, output ready);
endinterface

// ===== hw/rtl/bitmap_search_engine.sv =====
// one request at a time; the next is taken once the previous one reaches the output register
// searches walk one stored word per cycle over the single read port, then scan the hit word
// reset (synchronous, active high) clears the per-word valid bits at once: the map reads all zero
// right after reset, with no clearing pass
`include "bitmap_search_engine_assert.svh"

module bitmap_search_engine (
   input  logic          clock,
   input  logic          reset,
   bse_req_if.sink       req_ch,
   bse_rsp_if.source     rsp_ch
);

   localparam int WW = bse_pkg::WIDX_W;
   localparam int OW = bse_pkg::OFF_W;
   localparam int DW = bse_pkg::WORD_W;
   localparam logic [WW-1:0]         LAST_W = WW'(bse_pkg::WORDS - 1);
   localparam logic signed [12:0]    SIZE_S = 13'(bse_pkg::SIZE_BITS);
   localparam logic [11:0]           SIZE_U = 12'(bse_pkg::SIZE_BITS);

   bse_pkg::state_type   state_ff, state_in;
   bse_pkg::kind_type    kind_ff, kind_in;
   bse_pkg::mem_req_type mem_req;
   bse_pkg::res_type     res_ff, res_in, rsp_ff, rsp_in;

   logic                 want_ff, want_in;
   logic                 prev_ff, prev_in;
   logic                 first_ff, first_in;
   logic                 wv_ff, wv_in;
   logic                 hi_ok_ff, hi_ok_in;
   logic [WW-1:0]        w_ff, w_in;
   logic [OW-1:0]        off_ff, off_in;
   logic [bse_pkg::LEN_W-1:0] len_ff, len_in;
   logic [bse_pkg::CNT_W-1:0] acc_ff, acc_in;
   logic [DW-1:0]        lo_word_ff, lo_word_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;

   logic [DW-1:0]        rd_data;
   logic                 scan_start, scan_done;
   logic [OW-1:0]        scan_idx;
   logic [OW-1:0]        hit_off;

   logic                 accept;
   logic signed [12:0]   pos13, pos_p1, pos_m1, kn, kp;
   logic                 in_map, next_none, prev_none;
   logic [10:0]          lo11;
   logic [11:0]          hi_a, lo64, hi12;
   logic                 slice_empty;
   logic [bse_pkg::LEN_W-1:0] slice_len;

   logic [DW-1:0]        cand, cand_raw, pad_mask, first_mask, scan_vec;
   logic                 cand_any, walk_last, w_last;
   logic [DW-1:0]        rmw_word;
   logic                 rmw_bit;
   logic [2*DW-1:0]      slice_cat;
   logic [DW-1:0]        slice_mask, slice_hi;
   logic [6:0]           word_ones;

   function automatic logic [3:0] pop8(input logic [7:0] b);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(b[i]);
      end
      return n;
   endfunction

   function automatic logic [6:0] pop64(input logic [63:0] w);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 7'(pop8(w[i*8 +: 8]));
      end
      return n;
   endfunction

   bse_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   bse_scan u_scan (
      .clock (clock),
      .reset (reset),
      .start (scan_start),
      .vec   (scan_vec),
      .done  (scan_done),
      .index (scan_idx)
   );

   assign req_ch.ready = (state_ff == bse_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // request decode
   assign pos13     = {req_ch.position[11], req_ch.position};
   assign pos_p1    = pos13 + 13'sd1;
   assign pos_m1    = pos13 - 13'sd1;
   assign in_map    = !req_ch.position[11] && (pos13 < SIZE_S);
   assign kn        = pos_p1[12] ? 13'sd0 : pos_p1;
   assign next_none = (kn >= SIZE_S);
   assign kp        = (pos_m1 >= SIZE_S) ? (SIZE_S - 13'sd1) : pos_m1;
   assign prev_none = kp[12];

   assign lo11        = req_ch.position[11] ? 11'd0 : req_ch.position[10:0];
   assign hi_a        = ({1'b0, req_ch.end_position} > SIZE_U) ? SIZE_U
                                                                : {1'b0, req_ch.end_position};
   assign lo64        = {1'b0, lo11} + 12'd64;
   assign hi12        = (hi_a > lo64) ? lo64 : hi_a;
   assign slice_empty = (hi12 <= {1'b0, lo11});
   assign slice_len   = 7'(hi12 - {1'b0, lo11});

   // word walk for searches
   assign w_last     = (w_ff == LAST_W);
   assign walk_last  = prev_ff ? (w_ff == '0) : w_last;
   assign cand_raw   = want_ff ? rd_data : ~rd_data;
   assign pad_mask   = w_last ? bse_pkg::LAST_MASK : {DW{1'b1}};
   assign first_mask = prev_ff ? ({DW{1'b1}} >> (OW'(DW - 1) - off_ff))
                               : ({DW{1'b1}} << off_ff);
   assign cand       = cand_raw & pad_mask & (first_ff ? first_mask : {DW{1'b1}});
   assign cand_any   = |cand;

   // backward search scans the mirrored word for its lowest one
   always_comb begin
      for (int i = 0; i < DW; i++) begin
         scan_vec[i] = prev_ff ? cand[DW-1-i] : cand[i];
      end
   end

   assign hit_off = prev_ff ? (OW'(DW - 1) - scan_idx) : scan_idx;

   // read-modify-write of one bit
   assign rmw_bit = rd_data[off_ff];
   always_comb begin
      rmw_word = rd_data;
      if (kind_ff == bse_pkg::K_FLIP) begin
         rmw_word[off_ff] = ~rmw_bit;
      end else begin
         rmw_word[off_ff] = wv_ff;
      end
   end

   // slice assembly from two neighboring words
   assign slice_hi   = hi_ok_ff ? rd_data : '0;
   assign slice_cat  = {slice_hi, lo_word_ff} >> off_ff;
   assign slice_mask = len_ff[bse_pkg::LEN_W-1] ? {DW{1'b1}}
                     : (({{(DW-1){1'b0}}, 1'b1} << len_ff[OW-1:0]) - 1'b1);

   assign word_ones = pop64(rd_data);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bse_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_ch.kind)
                  bse_pkg::K_WRITE, bse_pkg::K_FLIP, bse_pkg::K_READ: begin
                     state_in = in_map ? bse_pkg::ST_RMW : bse_pkg::ST_DONE;
                  end
                  bse_pkg::K_NEXT_SET, bse_pkg::K_NEXT_UNSET: begin
                     state_in = next_none ? bse_pkg::ST_DONE : bse_pkg::ST_WALK;
                  end
                  bse_pkg::K_PREV_SET, bse_pkg::K_PREV_UNSET: begin
                     state_in = prev_none ? bse_pkg::ST_DONE : bse_pkg::ST_WALK;
                  end
                  bse_pkg::K_COUNT: state_in = bse_pkg::ST_COUNT;
                  bse_pkg::K_SET_ALL: state_in = bse_pkg::ST_FILL;
                  bse_pkg::K_SLICE: begin
                     state_in = slice_empty ? bse_pkg::ST_DONE : bse_pkg::ST_SLICE0;
                  end
                  default: state_in = bse_pkg::ST_DONE;
               endcase
            end
         end
         bse_pkg::ST_RMW: state_in = bse_pkg::ST_DONE;
         bse_pkg::ST_WALK: begin
            if (cand_any) begin
               state_in = bse_pkg::ST_SCAN;
            end else if (walk_last) begin
               state_in = bse_pkg::ST_DONE;
            end
         end
         bse_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = bse_pkg::ST_DONE;
            end
         end
         bse_pkg::ST_COUNT, bse_pkg::ST_FILL: begin
            if (w_last) begin
               state_in = bse_pkg::ST_DONE;
            end
         end
         bse_pkg::ST_SLICE0: state_in = bse_pkg::ST_SLICE1;
         bse_pkg::ST_SLICE1: state_in = bse_pkg::ST_DONE;
         bse_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = bse_pkg::ST_IDLE;
            end
         end
         default: state_in = bse_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      kind_in    = kind_ff;
      want_in    = want_ff;
      prev_in    = prev_ff;
      first_in   = first_ff;
      wv_in      = wv_ff;
      hi_ok_in   = hi_ok_ff;
      w_in       = w_ff;
      off_in     = off_ff;
      len_in     = len_ff;
      acc_in     = acc_ff;
      lo_word_in = lo_word_ff;
      res_in     = res_ff;
      mem_req    = '0;
      scan_start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         bse_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in = bse_pkg::kind_type'(req_ch.kind);
               wv_in   = req_ch.write_value;
               res_in  = '0;
               case (req_ch.kind)
                  bse_pkg::K_WRITE, bse_pkg::K_FLIP, bse_pkg::K_READ: begin
                     off_in          = req_ch.position[OW-1:0];
                     w_in            = req_ch.position[WW+OW-1:OW];
                     mem_req.rd_en   = in_map;
                     mem_req.rd_addr = req_ch.position[WW+OW-1:OW];
                  end
                  bse_pkg::K_NEXT_SET, bse_pkg::K_NEXT_UNSET: begin
                     want_in         = (req_ch.kind == bse_pkg::K_NEXT_SET);
                     prev_in         = 1'b0;
                     first_in        = 1'b1;
                     off_in          = kn[OW-1:0];
                     w_in            = kn[WW+OW-1:OW];
                     mem_req.rd_en   = !next_none;
                     mem_req.rd_addr = kn[WW+OW-1:OW];
                     if (next_none) begin
                        res_in.found_index = SIZE_U;
                     end
                  end
                  bse_pkg::K_PREV_SET, bse_pkg::K_PREV_UNSET: begin
                     want_in         = (req_ch.kind == bse_pkg::K_PREV_SET);
                     prev_in         = 1'b1;
                     first_in        = 1'b1;
                     off_in          = kp[OW-1:0];
                     w_in            = kp[WW+OW-1:OW];
                     mem_req.rd_en   = !prev_none;
                     mem_req.rd_addr = kp[WW+OW-1:OW];
                     if (prev_none) begin
                        res_in.found_index = '1;
                     end
                  end
                  bse_pkg::K_COUNT: begin
                     w_in            = '0;
                     acc_in          = '0;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = '0;
                  end
                  bse_pkg::K_CLEAR_ALL: mem_req.clr_all = 1'b1;
                  bse_pkg::K_SET_ALL: w_in = '0;
                  bse_pkg::K_SLICE: begin
                     off_in          = lo11[OW-1:0];
                     w_in            = lo11[WW+OW-1:OW];
                     len_in          = slice_len;
                     mem_req.rd_en   = !slice_empty;
                     mem_req.rd_addr = lo11[WW+OW-1:OW];
                  end
                  default: ;
               endcase
            end
         end
         bse_pkg::ST_RMW: begin
            if (kind_ff == bse_pkg::K_READ) begin
               res_in.bit_out = rmw_bit;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = w_ff;
               mem_req.wr_data = rmw_word;
            end
         end
         bse_pkg::ST_WALK: begin
            if (cand_any) begin
               scan_start = 1'b1;
            end else if (walk_last) begin
               res_in.found_index = prev_ff ? '1 : SIZE_U;
            end else begin
               // prefetch the neighbor word so the walk keeps one word per cycle
               first_in        = 1'b0;
               w_in            = prev_ff ? (w_ff - 1'b1) : (w_ff + 1'b1);
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = prev_ff ? (w_ff - 1'b1) : (w_ff + 1'b1);
            end
         end
         bse_pkg::ST_SCAN: begin
            if (scan_done) begin
               res_in.found_index = 12'({w_ff, hit_off});
            end
         end
         bse_pkg::ST_COUNT: begin
            acc_in = acc_ff + 11'(word_ones);
            if (w_last) begin
               res_in.ones_count = acc_ff + 11'(word_ones);
            end else begin
               w_in            = w_ff + 1'b1;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = w_ff + 1'b1;
            end
         end
         bse_pkg::ST_FILL: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = w_ff;
            mem_req.wr_data = pad_mask;
            if (!w_last) begin
               w_in = w_ff + 1'b1;
            end
         end
         bse_pkg::ST_SLICE0: begin
            lo_word_in      = rd_data;
            hi_ok_in        = !w_last;
            mem_req.rd_en   = !w_last;
            mem_req.rd_addr = w_ff + 1'b1;
         end
         bse_pkg::ST_SLICE1: begin
            res_in.slice_bits = slice_cat[DW-1:0] & slice_mask;
         end
         bse_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: ;
      endcase
   end

   // output register lets the next request start while a word waits
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bse_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      want_ff    <= want_in;
      prev_ff    <= prev_in;
      first_ff   <= first_in;
      wv_ff      <= wv_in;
      hi_ok_ff   <= hi_ok_in;
      w_ff       <= w_in;
      off_ff     <= off_in;
      len_ff     <= len_in;
      acc_ff     <= acc_in;
      lo_word_ff <= lo_word_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.bit_out     = rsp_ff.bit_out;
   assign rsp_ch.found_index = rsp_ff.found_index;
   assign rsp_ch.ones_count  = rsp_ff.ones_count;
   assign rsp_ch.slice_bits  = rsp_ff.slice_bits;

   `BSE_ASSERT(a_no_rw_overlap, clock, reset, !(mem_req.rd_en && mem_req.wr_en), "read and write in one cycle")
   `BSE_ASSERT(a_scan_in_scan, clock, reset, scan_done |-> (state_ff == bse_pkg::ST_SCAN), "scan result outside scan state")
   `BSE_ASSERT(a_accept_leaves_idle, clock, reset, accept |=> (state_ff != bse_pkg::ST_IDLE), "accepted request not started")
   `BSE_ASSERT(a_found_range, clock, reset, rsp_ch.valid |-> ((rsp_ch.found_index >= -12'sd1) && (rsp_ch.found_index <= $signed(SIZE_U))), "search index out of range")

endmodule

// ===== hw/rtl/bse_mem.sv =====
module bse_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  bse_pkg::mem_req_type         mem_req,
   output logic [bse_pkg::WORD_W-1:0]   rd_data
);

   logic [bse_pkg::WORD_W-1:0] mem_ff [bse_pkg::WORDS];
   logic [bse_pkg::WORD_W-1:0] rd_data_ff;
   logic                       rd_valid_ff, rd_valid_in;
   logic [bse_pkg::WORDS-1:0]  valid_ff, valid_in;

   // a word never written since reset or clear reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.clr_all) begin
         valid_in = '0;
      end
      if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr] = 1'b1;
      end
   end

   assign rd_valid_in = mem_req.rd_en ? valid_ff[mem_req.rd_addr] : rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/bse_scan.sv =====
module bse_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bse_pkg::WORD_W-1:0]  vec,
   output logic                        done,
   output logic [bse_pkg::OFF_W-1:0]   index
);

   localparam int BYTES = bse_pkg::WORD_W / 8;
   localparam int SEL_W = bse_pkg::OFF_W - 3;

   logic [BYTES-1:0] byte_any;
   logic [SEL_W-1:0] sel_c;
   logic [7:0]       byte_ff, byte_in;
   logic [SEL_W-1:0] bsel_ff, bsel_in;
   logic [2:0]       bit_c;
   logic [bse_pkg::OFF_W-1:0] index_ff, index_in;
   logic             v1_ff, v2_ff;

   // stage one: lowest byte holding a one
   always_comb begin
      sel_c = '0;
      for (int i = 0; i < BYTES; i++) begin
         byte_any[i] = |vec[i*8 +: 8];
      end
      for (int i = BYTES - 1; i >= 0; i--) begin
         if (byte_any[i]) begin
            sel_c = SEL_W'(i);
         end
      end
   end

   assign byte_in = vec[sel_c*8 +: 8];
   assign bsel_in = sel_c;

   // stage two: lowest one inside that byte
   always_comb begin
      bit_c = '0;
      for (int i = 7; i >= 0; i--) begin
         if (byte_ff[i]) begin
            bit_c = 3'(i);
         end
      end
   end

   assign index_in = {bsel_ff, bit_c};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      bsel_ff  <= bsel_in;
      index_ff <= index_in;
   end

   assign done  = v2_ff;
   assign index = index_ff;

endmodule

// ===== tb/bse_scoreboard_pkg.sv =====
`timescale 1ns / 100ps

package bse_scoreboard_pkg;
   import bse_pkg::*;

   class bse_scoreboard;
      bit [SIZE_BITS-1:0] map_bits;
      res_type            expected_q[$];
      int                 n_checked;
      int                 n_errors;

      function new();
         map_bits   = '0;
         n_checked  = 0;
         n_errors   = 0;
      endfunction

      // nearest bit equal to want strictly above p, SIZE_BITS if none
      function int find_after(int p, bit want);
         int k;
         k = p + 1;
         if (k < 0) k = 0;
         for (; k < SIZE_BITS; k++)
            if (map_bits[k] == want) return k;
         return SIZE_BITS;
      endfunction

      // nearest bit equal to want strictly below p, -1 if none
      function int find_before(int p, bit want);
         int k;
         k = p - 1;
         if (k >= SIZE_BITS) k = SIZE_BITS - 1;
         for (; k >= 0; k--)
            if (map_bits[k] == want) return k;
         return -1;
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic signed [POS_W-1:0] position,
                                 logic [END_W-1:0] end_position, logic write_value);
         int      p;
         int      k;
         int      lo;
         int      hi;
         bit      in_range;
         res_type exp_res;
         p        = position;
         in_range = (p >= 0) && (p < SIZE_BITS);
         exp_res  = '0;
         case (kind)
            K_WRITE:      if (in_range) map_bits[p] = write_value;
            K_FLIP:       if (in_range) map_bits[p] = ~map_bits[p];
            K_READ:       if (in_range) exp_res.bit_out = map_bits[p];
            K_NEXT_SET:   exp_res.found_index = POS_W'(find_after(p, 1'b1));
            K_NEXT_UNSET: exp_res.found_index = POS_W'(find_after(p, 1'b0));
            K_PREV_SET:   exp_res.found_index = POS_W'(find_before(p, 1'b1));
            K_PREV_UNSET: exp_res.found_index = POS_W'(find_before(p, 1'b0));
            K_COUNT:      exp_res.ones_count = CNT_W'($countones(map_bits));
            K_CLEAR_ALL:  map_bits = '0;
            K_SET_ALL:    map_bits = '1;
            K_SLICE: begin
               lo = (p < 0) ? 0 : p;
               hi = end_position;
               if (hi > SIZE_BITS) hi = SIZE_BITS;
               if (hi > lo + WORD_W) hi = lo + WORD_W;
               for (k = lo; k < hi; k++)
                  exp_res.slice_bits[k - lo] = map_bits[k];
            end
            default: ;
         endcase
         expected_q.push_back(exp_res);
      endfunction

      function void check_result(logic bit_out, logic signed [POS_W-1:0] found_index,
                                 logic [CNT_W-1:0] ones_count, logic [WORD_W-1:0] slice_bits);
         res_type exp_res;
         if (expected_q.size() == 0) begin
            $error("result word with no request pending");
            n_errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         n_checked++;
         if (bit_out !== exp_res.bit_out) begin
            $error("bit_out expected %0d actual %0d", exp_res.bit_out, bit_out);
            n_errors++;
         end
         if (found_index !== exp_res.found_index) begin
            $error("found_index expected %0d actual %0d", exp_res.found_index, found_index);
            n_errors++;
         end
         if (ones_count !== exp_res.ones_count) begin
            $error("ones_count expected %0d actual %0d", exp_res.ones_count, ones_count);
            n_errors++;
         end
         if (slice_bits !== exp_res.slice_bits) begin
            $error("slice_bits expected %h actual %h", exp_res.slice_bits, slice_bits);
            n_errors++;
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import bse_pkg::*;
   import bse_scoreboard_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_ITEMS    = 1830;
   localparam int TAIL_CYCLES     = 40;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN_FIRST = 4'd11;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN_LAST  = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bse_req_if req_ch();
   bse_rsp_if rsp_ch();

   bitmap_search_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bse_scoreboard bitmap_sb = new();

   bit quiet_stretch = 1'b0;
   bit hold_off_req  = 1'b0;
   int stuck_cycles  = 0;
   int requests_sent = 0;
   int kind_hits[16];

   always #10 clock = ~clock;

   // result side: random back-pressure, one long hold-off on request
   initial begin : rsp_sink
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= quiet_stretch || ($urandom_range(99) >= 20);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         bitmap_sb.check_result(rsp_ch.bit_out, rsp_ch.found_index, rsp_ch.ones_count,
                                rsp_ch.slice_bits);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_request(logic [KIND_W-1:0] kind, logic signed [POS_W-1:0] position,
                               logic [END_W-1:0] end_position, logic write_value);
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.position     <= position;
      req_ch.end_position <= end_position;
      req_ch.write_value  <= write_value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bitmap_sb.note_request(kind, position, end_position, write_value);
      requests_sent++;
      kind_hits[kind]++;
   endtask

   task automatic maybe_idle();
      if (!quiet_stretch && $urandom_range(99) < 20) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (bitmap_sb.expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [POS_W-1:0] pick_position();
      int r;
      int x;
      r = $urandom_range(99);
      if (r < 70) begin
         x = $urandom_range(SIZE_BITS - 1);
      end else if (r < 80) begin
         // around a word boundary
         x = $urandom_range(WORDS - 1) * WORD_W + $urandom_range(2) - 1;
      end else if (r < 90) begin
         case ($urandom_range(3))
            0:       x = -1;
            1:       x = 0;
            2:       x = SIZE_BITS - 1;
            default: x = SIZE_BITS;
         endcase
      end else begin
         x = $urandom();
      end
      return POS_W'(x);
   endfunction

   initial begin : stimulus
      int                      i;
      int                      r;
      int                      one_pct;
      int                      base;
      logic [KIND_W-1:0]       kind;
      logic signed [POS_W-1:0] pos;
      logic [END_W-1:0]        endp;
      logic                    wv;

      one_pct = 50;
      req_ch.valid        <= 1'b0;
      req_ch.kind         <= '0;
      req_ch.position     <= '0;
      req_ch.end_position <= '0;
      req_ch.write_value  <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edges of the map, out of range access, clamped search starts and slice bounds
      send_request(K_READ, 0, 0, 1'b0);
      send_request(K_WRITE, 0, 0, 1'b1);
      send_request(K_WRITE, POS_W'(SIZE_BITS - 1), 0, 1'b1);
      send_request(K_WRITE, -1, 0, 1'b1);
      send_request(K_WRITE, POS_W'(SIZE_BITS), 0, 1'b1);
      send_request(K_READ, POS_W'(SIZE_BITS - 1), 0, 1'b0);
      send_request(K_READ, 12'sh800, 0, 1'b0);
      send_request(K_NEXT_SET, 12'sh800, 0, 1'b0);
      send_request(K_NEXT_SET, 0, 0, 1'b0);
      send_request(K_NEXT_UNSET, POS_W'(SIZE_BITS - 2), 0, 1'b0);
      send_request(K_PREV_SET, 12'sh7ff, 0, 1'b0);
      send_request(K_PREV_SET, 0, 0, 1'b0);
      send_request(K_PREV_UNSET, POS_W'(SIZE_BITS), 0, 1'b0);
      send_request(K_COUNT, 0, 0, 1'b0);
      send_request(K_SLICE, -5, 11'h7ff, 1'b0);
      send_request(K_SLICE, POS_W'(SIZE_BITS - 24), END_W'(SIZE_BITS), 1'b0);
      send_request(K_SLICE, 10, 5, 1'b0);
      send_request(K_SET_ALL, 0, 0, 1'b0);
      send_request(K_NEXT_UNSET, -1, 0, 1'b0);
      send_request(K_PREV_UNSET, 12'sh7ff, 0, 1'b0);
      send_request(K_COUNT, 0, 0, 1'b0);
      send_request(K_FLIP, POS_W'(SIZE_BITS / 2), 0, 1'b0);
      send_request(K_PREV_UNSET, POS_W'(SIZE_BITS), 0, 1'b0);
      send_request(K_CLEAR_ALL, 0, 0, 1'b0);
      send_request(KIND_UNKNOWN_LAST, 12'sh7ff, 11'h7ff, 1'b1);
      wait_for_results();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         // switch between sparse, dense and mixed maps
         if (i % 150 == 0) begin
            case ($urandom_range(2))
               0: begin
                  one_pct = 10;
                  send_request(K_CLEAR_ALL, 0, 0, 1'b0);
               end
               1: begin
                  one_pct = 90;
                  send_request(K_SET_ALL, 0, 0, 1'b0);
               end
               default: one_pct = 50;
            endcase
         end
         if (i == 300) hold_off_req = 1'b1;
         if (i == 700) quiet_stretch = 1'b1;
         if (i == 1000) quiet_stretch = 1'b0;
         if (i == 1200) wait_for_results();

         r = $urandom_range(99);
         if (r < 28)      kind = K_WRITE;
         else if (r < 36) kind = K_FLIP;
         else if (r < 44) kind = K_READ;
         else if (r < 52) kind = K_NEXT_SET;
         else if (r < 60) kind = K_NEXT_UNSET;
         else if (r < 68) kind = K_PREV_SET;
         else if (r < 76) kind = K_PREV_UNSET;
         else if (r < 82) kind = K_COUNT;
         else if (r < 83) kind = K_CLEAR_ALL;
         else if (r < 84) kind = K_SET_ALL;
         else if (r < 98) kind = K_SLICE;
         else             kind = KIND_W'(KIND_UNKNOWN_FIRST + $urandom_range(4));

         pos = pick_position();
         wv  = ($urandom_range(99) < one_pct);
         if ($urandom_range(9) == 0) begin
            endp = END_W'($urandom_range(11'h7ff));
         end else begin
            base = (pos < 0) ? 0 : pos;
            endp = END_W'(base + $urandom_range(70));
         end
         send_request(kind, pos, endp, wv);
         maybe_idle();
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d searches, %0d slices, %0d counts, %0d unknown kinds",
               requests_sent,
               kind_hits[K_NEXT_SET] + kind_hits[K_NEXT_UNSET] + kind_hits[K_PREV_SET] +
               kind_hits[K_PREV_UNSET],
               kind_hits[K_SLICE], kind_hits[K_COUNT],
               kind_hits[11] + kind_hits[12] + kind_hits[13] + kind_hits[14] + kind_hits[15]);
      $display("checked %0d result words, %0d mismatches", bitmap_sb.n_checked,
               bitmap_sb.n_errors);
      if (bitmap_sb.n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
